// File: hdl/ihex_pkg.sv
// ============================================================================
// Intel HEX loader package
// Shared types, character codes and record codes for the record loader.
// ============================================================================
package ihex_pkg;

  // Characters with a meaning of their own.
  localparam logic [7:0] CHAR_NEWLINE = 8'd10;
  localparam logic [7:0] CHAR_COLON   = 8'd58;

  // Byte positions on a record line.
  localparam logic [8:0] MIN_LINE_BYTES = 9'd5;
  localparam logic [8:0] PAYLOAD_START  = 9'd4;
  localparam logic [8:0] INDEX_MAX      = 9'd511;
  localparam logic [8:0] IDX_LENGTH     = 9'd0;
  localparam logic [8:0] IDX_OFFSET_HI  = 9'd1;
  localparam logic [8:0] IDX_OFFSET_LO  = 9'd2;
  localparam logic [8:0] IDX_KIND       = 9'd3;
  localparam logic [8:0] IDX_PAY_FIRST  = 9'd4;
  localparam logic [8:0] IDX_PAY_SECOND = 9'd5;

  // Record types.
  localparam logic [7:0] KIND_DATA    = 8'h00;
  localparam logic [7:0] KIND_EXT_SEG = 8'h02;
  localparam logic [7:0] KIND_EXT_LIN = 8'h04;

  // Queue between the character front end and the record back end.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    LM_START,
    LM_RECORD,
    LM_SKIP
  } line_mode_t;

  // One decoded event: either a byte of a record line or the end of a
  // record line long enough to commit its base update.
  typedef struct packed {
    logic       is_end;
    logic [7:0] data;
    logic [8:0] index;
  } token_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } hex_digit_t;

  function automatic hex_digit_t ascii_to_nibble(input logic [7:0] c);
    hex_digit_t d;
    d.valid = 1'b1;
    d.value = 4'd0;
    case (c) inside
      [8'h30:8'h39]: d.value = 4'(c - 8'h30);
      [8'h41:8'h46]: d.value = 4'(c - 8'h37);
      [8'h61:8'h66]: d.value = 4'(c - 8'h57);
      default: d.valid = 1'b0;
    endcase
    return d;
  endfunction

endpackage

// File: hdl/ihex_front.sv
// ============================================================================
// Intel HEX character front end
// Tracks line state, pairs hex digits into bytes and emits byte and
// line-end transactions toward the record back end.
// ============================================================================
module ihex_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_character,
  input  logic              q_full,
  output logic              q_push,
  output ihex_pkg::token_t  q_push_tok
);

  ihex_pkg::line_mode_t mode_r, mode_nxt;
  logic       pending_r, pending_nxt;
  logic [3:0] high_r, high_nxt;
  logic [8:0] idx_r, idx_nxt;
  logic       accept;
  ihex_pkg::hex_digit_t digit;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign digit    = ihex_pkg::ascii_to_nibble(in_character);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= ihex_pkg::LM_START;
      pending_r <= 1'b0;
      high_r    <= 4'd0;
      idx_r     <= 9'd0;
    end else begin
      mode_r    <= mode_nxt;
      pending_r <= pending_nxt;
      high_r    <= high_nxt;
      idx_r     <= idx_nxt;
    end
  end

  always_comb begin
    mode_nxt    = mode_r;
    pending_nxt = pending_r;
    high_nxt    = high_r;
    idx_nxt     = idx_r;
    q_push      = 1'b0;
    q_push_tok  = '0;
    if (accept) begin
      if (in_character == ihex_pkg::CHAR_NEWLINE) begin
        // Only a record line with the full header and at least one payload byte commits anything at its end.
        if (mode_r == ihex_pkg::LM_RECORD && idx_r >= ihex_pkg::MIN_LINE_BYTES) begin
          q_push            = 1'b1;
          q_push_tok.is_end = 1'b1;
        end
        mode_nxt    = ihex_pkg::LM_START;
        pending_nxt = 1'b0;
        high_nxt    = 4'd0;
        idx_nxt     = 9'd0;
      end else begin
        case (mode_r)
          ihex_pkg::LM_START: begin
            mode_nxt = (in_character == ihex_pkg::CHAR_COLON) ? ihex_pkg::LM_RECORD
                                                               : ihex_pkg::LM_SKIP;
          end
          ihex_pkg::LM_RECORD: begin
            if (digit.valid) begin
              if (!pending_r) begin
                high_nxt    = digit.value;
                pending_nxt = 1'b1;
              end else begin
                pending_nxt      = 1'b0;
                q_push           = 1'b1;
                q_push_tok.data  = {high_r, digit.value};
                q_push_tok.index = idx_r;
                if (idx_r != ihex_pkg::INDEX_MAX) begin
                  idx_nxt = idx_r + 9'd1;
                end
              end
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

`ifndef SYNTHESIS
  // A line end always leaves the digit pairing and line state cleared.
  a_newline_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_character == ihex_pkg::CHAR_NEWLINE
      |=> !pending_r && idx_r == 9'd0 && mode_r == ihex_pkg::LM_START)
    else $error("line state not cleared after line end");

  a_push_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> accept && !q_full)
    else $error("token pushed without an accepted character");

  a_end_needs_header: assert property (@(posedge clk) disable iff (!rst_n)
    q_push && q_push_tok.is_end |-> idx_r >= ihex_pkg::MIN_LINE_BYTES)
    else $error("line end token for a short line");
`endif

endmodule

// File: hdl/ihex_queue.sv
// ============================================================================
// Intel HEX token queue
// Short first-in first-out buffer that decouples the character front end
// from the record back end.
// ============================================================================
module ihex_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ihex_pkg::token_t  push_tok,
  output logic              full,
  output logic              valid,
  input  logic              pop,
  output ihex_pkg::token_t  pop_tok
);

  ihex_pkg::token_t               slot_r [ihex_pkg::QDEPTH];
  logic [ihex_pkg::QPTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [ihex_pkg::QPTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [ihex_pkg::QCNT_W-1:0]    count_r, count_nxt;

  assign full    = (count_r == ihex_pkg::QCNT_W'(ihex_pkg::QDEPTH));
  assign valid   = (count_r != '0);
  assign pop_tok = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ihex_pkg::QPTR_W'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? ihex_pkg::QPTR_W'(rd_ptr_r + 1'b1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = ihex_pkg::QCNT_W'(count_r + 1'b1);
    end else if (pop && !push) begin
      count_nxt = ihex_pkg::QCNT_W'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_tok;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && !valid))
    else $error("pop from an empty queue");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= ihex_pkg::QCNT_W'(ihex_pkg::QDEPTH))
    else $error("queue count beyond depth");
`endif

endmodule

// File: hdl/ihex_back.sv
// ============================================================================
// Intel HEX record back end
// Collects record header fields, holds the address base and issues one
// flash write for each data byte within the declared record length.
// ============================================================================
module ihex_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  ihex_pkg::token_t  q_tok,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [31:0]       out_write_address,
  output logic [7:0]        out_write_data
);

  logic [31:0] base_r, base_nxt;
  logic [7:0]  length_r, length_nxt;
  logic [15:0] offset_r, offset_nxt;
  logic [7:0]  kind_r, kind_nxt;
  logic [7:0]  pay_first_r, pay_first_nxt;
  logic [7:0]  pay_second_r, pay_second_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_addr_r, out_addr_nxt;
  logic [7:0]  out_data_r, out_data_nxt;
  logic [8:0]  pay_idx;
  logic [15:0] base_value;
  logic        is_write;

  assign q_pop             = q_valid && (!out_valid_r || out_ready);
  assign out_valid         = out_valid_r;
  assign out_write_address = out_addr_r;
  assign out_write_data    = out_data_r;

  assign pay_idx    = q_tok.index - ihex_pkg::PAYLOAD_START;
  assign base_value = {pay_first_r, pay_second_r};
  assign is_write   = !q_tok.is_end && kind_r == ihex_pkg::KIND_DATA
                      && q_tok.index >= ihex_pkg::PAYLOAD_START
                      && pay_idx < {1'b0, length_r};

  always_comb begin
    base_nxt       = base_r;
    length_nxt     = length_r;
    offset_nxt     = offset_r;
    kind_nxt       = kind_r;
    pay_first_nxt  = pay_first_r;
    pay_second_nxt = pay_second_r;
    out_addr_nxt   = out_addr_r;
    out_data_nxt   = out_data_r;
    out_valid_nxt  = out_ready ? 1'b0 : out_valid_r;
    if (q_pop) begin
      if (q_tok.is_end) begin
        // Only one base is ever live, so the sum of both is kept as one word.
        case (kind_r)
          ihex_pkg::KIND_DATA:    base_nxt = base_r;
          ihex_pkg::KIND_EXT_SEG: base_nxt = {12'd0, base_value, 4'd0};
          ihex_pkg::KIND_EXT_LIN: base_nxt = {base_value, 16'd0};
          default:                base_nxt = 32'd0;
        endcase
      end else begin
        case (q_tok.index)
          ihex_pkg::IDX_LENGTH: begin
            length_nxt     = q_tok.data;
            pay_second_nxt = 8'd0;
          end
          ihex_pkg::IDX_OFFSET_HI:  offset_nxt     = {q_tok.data, offset_r[7:0]};
          ihex_pkg::IDX_OFFSET_LO:  offset_nxt     = {offset_r[15:8], q_tok.data};
          ihex_pkg::IDX_KIND:       kind_nxt       = q_tok.data;
          ihex_pkg::IDX_PAY_FIRST:  pay_first_nxt  = q_tok.data;
          ihex_pkg::IDX_PAY_SECOND: pay_second_nxt = q_tok.data;
          default: begin
          end
        endcase
        if (is_write) begin
          out_valid_nxt = 1'b1;
          out_addr_nxt  = base_r + {16'd0, offset_r} + {23'd0, pay_idx};
          out_data_nxt  = q_tok.data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r       <= 32'd0;
      length_r     <= 8'd0;
      offset_r     <= 16'd0;
      kind_r       <= 8'd0;
      pay_first_r  <= 8'd0;
      pay_second_r <= 8'd0;
      out_valid_r  <= 1'b0;
    end else begin
      base_r       <= base_nxt;
      length_r     <= length_nxt;
      offset_r     <= offset_nxt;
      kind_r       <= kind_nxt;
      pay_first_r  <= pay_first_nxt;
      pay_second_r <= pay_second_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_addr_r <= out_addr_nxt;
    out_data_r <= out_data_nxt;
  end

`ifndef SYNTHESIS
  // A held write must never be overwritten by a new token.
  a_no_pop_when_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |-> !q_pop)
    else $error("token taken while a write is still held");

  a_pop_needs_token: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("token taken from an empty queue");

  a_held_write_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready
      |=> out_valid_r && $stable(out_addr_r) && $stable(out_data_r))
    else $error("held write changed before it was taken");
`endif

endmodule

// File: hdl/intel_hex_record_loader.sv
// ============================================================================
// Intel HEX record loader
// Parses Intel HEX text one character per transaction and issues flash
// byte writes for the data records.
// ============================================================================
//
//   Channel   Ports                                         Direction
//   --------  --------------------------------------------  ---------
//   input     in_valid, in_ready, in_character              in
//   result    out_valid, out_ready, out_write_address,      out
//             out_write_data
//
// One character is accepted per cycle while the queue is not full. A data byte
// is offered on the result channel after it passes through the four-entry
// queue and then the output register, which holds it until it is taken.
// Reset clears the line state, the queue and the address base to zero.
// A stalled result channel fills the queue; in_ready falls only when the queue
// is full, so the front end keeps taking characters that produce no token.
// ============================================================================
module intel_hex_record_loader (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_character,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_write_address,
  output logic [7:0]  out_write_data
);

  logic             q_full;
  logic             q_push;
  ihex_pkg::token_t q_push_tok;
  logic             q_valid;
  logic             q_pop;
  ihex_pkg::token_t q_pop_tok;

  ihex_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_character (in_character),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_push_tok   (q_push_tok)
  );

  ihex_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_tok (q_push_tok),
    .full     (q_full),
    .valid    (q_valid),
    .pop      (q_pop),
    .pop_tok  (q_pop_tok)
  );

  ihex_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_tok             (q_pop_tok),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_write_address (out_write_address),
    .out_write_data    (out_write_data)
  );

endmodule

// File: bench/testbench.sv
// ============================================================================
// Intel HEX record loader testbench
// Feeds Intel HEX text one character per transaction and checks every flash
// write against a cycle-free model of the parser. The stimulus starts with
// hand-built records: address wrap, segment and linear bases, noise, odd
// digits and short lines. Random lines follow, mostly well-formed records
// with random content. Both channels idle at random.
// ============================================================================
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] CHAR_CR    = 8'd13;
  localparam logic [7:0] KIND_EOF   = 8'h01;
  localparam int         RAND_CHARS = 400;

  typedef struct {
    logic [31:0] address;
    logic [7:0]  data;
  } flash_write_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_character = 8'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_write_address;
  logic [7:0]  out_write_data;

  logic [7:0]   char_q[$];
  flash_write_t write_q[$];
  int           error_count = 0;
  logic         in_done = 1'b0;
  int           in_gap = 0;
  int           in_calm = 0;
  int           out_stall = 0;
  int           out_calm = 0;
  flash_write_t seen;

  // Parser model state.
  ihex_pkg::line_mode_t ln_mode = ihex_pkg::LM_START;
  logic        ln_half   = 1'b0;
  logic [3:0]  ln_high   = 4'd0;
  logic [8:0]  ln_count  = 9'd0;
  logic [7:0]  ln_len    = 8'd0;
  logic [15:0] ln_off    = 16'd0;
  logic [7:0]  ln_kind   = 8'd0;
  logic [7:0]  ln_first  = 8'd0;
  logic [7:0]  ln_second = 8'd0;
  logic [15:0] seg_base  = 16'd0;
  logic [15:0] lin_base  = 16'd0;

  intel_hex_record_loader DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_character      (in_character),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_write_address (out_write_address),
    .out_write_data    (out_write_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Returns {digit valid, digit value}.
  function automatic logic [4:0] nibble_of(input logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b1, 4'(c - "0")};
    if (c >= "A" && c <= "F") return {1'b1, 4'(c - "A" + 8'd10)};
    if (c >= "a" && c <= "f") return {1'b1, 4'(c - "a" + 8'd10)};
    return 5'd0;
  endfunction

  task automatic absorb_char(input logic [7:0] c);
    logic [4:0]   nib;
    logic [7:0]   b;
    logic [8:0]   idx;
    flash_write_t w;
    if (c == ihex_pkg::CHAR_NEWLINE) begin
      if (ln_mode == ihex_pkg::LM_RECORD && ln_count >= ihex_pkg::MIN_LINE_BYTES) begin
        if (ln_kind == ihex_pkg::KIND_EXT_SEG) begin
          seg_base = {ln_first, ln_second};
          lin_base = 16'd0;
        end else if (ln_kind == ihex_pkg::KIND_EXT_LIN) begin
          lin_base = {ln_first, ln_second};
          seg_base = 16'd0;
        end else if (ln_kind != ihex_pkg::KIND_DATA) begin
          seg_base = 16'd0;
          lin_base = 16'd0;
        end
      end
      ln_mode = ihex_pkg::LM_START;
      ln_half = 1'b0;
      ln_high = 4'd0;
      ln_count = 9'd0;
      ln_len = 8'd0;
      ln_off = 16'd0;
      ln_kind = 8'd0;
      ln_first = 8'd0;
      ln_second = 8'd0;
    end else if (ln_mode == ihex_pkg::LM_START) begin
      ln_mode = (c == ihex_pkg::CHAR_COLON) ? ihex_pkg::LM_RECORD : ihex_pkg::LM_SKIP;
    end else if (ln_mode == ihex_pkg::LM_RECORD) begin
      nib = nibble_of(c);
      if (nib[4]) begin
        if (!ln_half) begin
          ln_high = nib[3:0];
          ln_half = 1'b1;
        end else begin
          ln_half = 1'b0;
          b = {ln_high, nib[3:0]};
          idx = ln_count;
          if (ln_count < ihex_pkg::INDEX_MAX) ln_count = ln_count + 9'd1;
          case (idx)
            ihex_pkg::IDX_LENGTH:     ln_len = b;
            ihex_pkg::IDX_OFFSET_HI:  ln_off[15:8] = b;
            ihex_pkg::IDX_OFFSET_LO:  ln_off[7:0] = b;
            ihex_pkg::IDX_KIND:       ln_kind = b;
            ihex_pkg::IDX_PAY_FIRST:  ln_first = b;
            ihex_pkg::IDX_PAY_SECOND: ln_second = b;
            default: ;
          endcase
          if (idx >= ihex_pkg::PAYLOAD_START && ln_kind == ihex_pkg::KIND_DATA &&
              (idx - ihex_pkg::PAYLOAD_START) < {1'b0, ln_len}) begin
            w.address = {lin_base, 16'h0000} + {12'h000, seg_base, 4'h0}
                        + {16'h0000, ln_off} + 32'(idx - ihex_pkg::PAYLOAD_START);
            w.data = b;
            write_q.push_back(w);
          end
        end
      end
    end
  endtask

  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // Source side: one character per transaction, random gaps between them.
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_done)) begin
      if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (char_q.size() != 0) begin
        in_character <= char_q.pop_front();
        in_valid <= 1'b1;
        in_gap <= pick_gap(in_calm);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Sink side: random back-pressure.
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_stall > 0) begin
        out_ready <= 1'b0;
        out_stall <= out_stall - 1;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) out_stall <= pick_gap(out_calm);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_done <= 1'b0;
    end else begin
      in_done <= in_valid && in_ready;
      if (in_valid && in_ready) absorb_char(in_character);
      if (out_valid && out_ready) begin
        if (write_q.size() == 0) begin
          $error("unexpected write: address %08h data %02h",
                 out_write_address, out_write_data);
          error_count++;
        end else begin
          seen = write_q.pop_front();
          if (out_write_address !== seen.address) begin
            $error("write_address: expected %08h, actual %08h",
                   seen.address, out_write_address);
            error_count++;
          end
          if (out_write_data !== seen.data) begin
            $error("write_data: expected %02h, actual %02h",
                   seen.data, out_write_data);
            error_count++;
          end
        end
      end
    end
  end

  function automatic logic [7:0] digit_char(input logic [3:0] n, input bit lower);
    if (n < 4'd10) return "0" + 8'(n);
    return (lower ? "a" : "A") + 8'(n) - 8'd10;
  endfunction

  task automatic push_byte(input logic [7:0] b);
    char_q.push_back(digit_char(b[7:4], 1'($urandom_range(0, 1))));
    char_q.push_back(digit_char(b[3:0], 1'($urandom_range(0, 1))));
  endtask

  task automatic push_head(input logic [7:0] len, input logic [15:0] off,
                           input logic [7:0] kind);
    char_q.push_back(ihex_pkg::CHAR_COLON);
    push_byte(len);
    push_byte(off[15:8]);
    push_byte(off[7:0]);
    push_byte(kind);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) char_q.push_back(s[i]);
  endtask

  function automatic logic [7:0] noise_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == ihex_pkg::CHAR_NEWLINE);
    return c;
  endfunction

  task automatic gen_line();
    int         r;
    int         supply;
    logic [7:0] kind;
    logic [7:0] len;
    logic [7:0] lead;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      r = $urandom_range(0, 99);
      if (r < 60) kind = ihex_pkg::KIND_DATA;
      else if (r < 72) kind = ihex_pkg::KIND_EXT_SEG;
      else if (r < 84) kind = ihex_pkg::KIND_EXT_LIN;
      else if (r < 90) kind = KIND_EOF;
      else kind = 8'($urandom_range(0, 255));
      if (kind == ihex_pkg::KIND_DATA)
        len = ($urandom_range(0, 9) != 0) ? 8'($urandom_range(0, 8))
                                          : 8'($urandom_range(9, 255));
      else
        len = ($urandom_range(0, 4) != 0) ? 8'd2 : 8'($urandom_range(0, 255));
      supply = (len > 16) ? $urandom_range(0, 12) : len + 1;
      r = $urandom_range(0, 9);
      if (r == 0) supply = $urandom_range(0, supply);
      else if (r == 1) supply = supply + $urandom_range(1, 3);
      push_head(len, 16'($urandom_range(0, 65535)), kind);
      for (int i = 0; i < supply; i++) begin
        if ($urandom_range(0, 19) == 0) char_q.push_back(noise_char());
        push_byte(8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 9) == 0)
        char_q.push_back(digit_char(4'($urandom_range(0, 15)), 1'b0));
      if ($urandom_range(0, 2) == 0) char_q.push_back(CHAR_CR);
    end else if (r < 80) begin
      // Too few bytes to count as a record.
      char_q.push_back(ihex_pkg::CHAR_COLON);
      repeat ($urandom_range(0, 4)) push_byte(8'($urandom_range(0, 255)));
    end else if (r < 88) begin
      do lead = noise_char(); while (lead == ihex_pkg::CHAR_COLON);
      char_q.push_back(lead);
      repeat ($urandom_range(0, 12)) char_q.push_back(noise_char());
    end else if (r >= 93) begin
      repeat ($urandom_range(1, 8)) char_q.push_back(8'($urandom_range(0, 255)));
    end
    char_q.push_back(ihex_pkg::CHAR_NEWLINE);
  endtask

  initial begin
    int stop_at;
    rst_n = 1'b0;

    // Linear base at the top, then a data record that wraps the address space.
    push_head(8'd2, 16'h0000, ihex_pkg::KIND_EXT_LIN);
    push_byte(8'hFF);
    push_byte(8'hFF);
    push_byte(8'hFC);
    char_q.push_back(CHAR_CR);
    char_q.push_back(ihex_pkg::CHAR_NEWLINE);
    push_head(8'd3, 16'hFFFE, ihex_pkg::KIND_DATA);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(8'h5A);
    push_byte(8'hA8);
    char_q.push_back(ihex_pkg::CHAR_NEWLINE);
    // Segment base; noise between digit pairs and a lone trailing digit.
    push_head(8'd2, 16'h0000, ihex_pkg::KIND_EXT_SEG);
    push_byte(8'h10);
    push_byte(8'h00);
    char_q.push_back(ihex_pkg::CHAR_NEWLINE);
    push_head(8'd2, 16'h0010, ihex_pkg::KIND_DATA);
    char_q.push_back(8'h00);
    push_byte(8'hA5);
    push_text(" ");
    char_q.push_back(8'hFF);
    push_byte(8'h3C);
    push_text("7");
    char_q.push_back(ihex_pkg::CHAR_NEWLINE);
    // Bytes past the declared length are not written.
    push_head(8'd1, 16'h0020, ihex_pkg::KIND_DATA);
    push_byte(8'h11);
    push_byte(8'h22);
    push_byte(8'h33);
    char_q.push_back(ihex_pkg::CHAR_NEWLINE);
    // Short line, empty line, line without a leading colon.
    char_q.push_back(ihex_pkg::CHAR_COLON);
    push_byte(8'h02);
    push_byte(8'h00);
    char_q.push_back(ihex_pkg::CHAR_NEWLINE);
    char_q.push_back(ihex_pkg::CHAR_NEWLINE);
    push_text("#:02000004");
    char_q.push_back(8'hFF);
    char_q.push_back(ihex_pkg::CHAR_NEWLINE);
    // An unknown record type clears both bases.
    push_head(8'd2, 16'h0000, 8'h55);
    push_byte(8'h12);
    push_byte(8'h34);
    char_q.push_back(ihex_pkg::CHAR_NEWLINE);
    push_head(8'd1, 16'h0040, ihex_pkg::KIND_DATA);
    push_byte(8'h77);
    char_q.push_back(ihex_pkg::CHAR_NEWLINE);
    push_head(8'd2, 16'h0000, ihex_pkg::KIND_EXT_SEG);
    push_byte(8'hFF);
    push_byte(8'hFF);
    char_q.push_back(ihex_pkg::CHAR_NEWLINE);
    push_head(8'd2, 16'hFFFF, ihex_pkg::KIND_DATA);
    push_byte(8'h81);
    push_byte(8'h7E);
    char_q.push_back(ihex_pkg::CHAR_NEWLINE);
    push_head(8'd0, 16'h0000, KIND_EOF);
    push_byte(8'hFF);
    char_q.push_back(ihex_pkg::CHAR_NEWLINE);

    stop_at = char_q.size() + RAND_CHARS;
    while (char_q.size() < stop_at) gen_line();
    // The last line has no line end.
    push_head(8'd2, 16'h2000, ihex_pkg::KIND_DATA);
    push_byte(8'($urandom_range(0, 255)));
    push_byte(8'($urandom_range(0, 255)));

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (char_q.size() != 0 || in_valid) @(posedge clk);
    while (write_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $error("timeout with %0d writes still expected", write_q.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule
